### src/spq_pkg.sv
// Package for the stable priority queue: default sizes, operation and
// status codes, and the command struct that drives the cell chain.
// No dependencies.
package spq_pkg;

   localparam int SPQ_QUEUE_DEPTH   = 128;
   localparam int SPQ_PRIORITY_BITS = 8;

   localparam int SPQ_TIME_BITS  = 32;
   localparam int SPQ_OUT_PRIO_W = 8;
   localparam int SPQ_TOTAL_W    = 8;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // One command per accepted item, broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
   } spq_cmd_type;

endpackage

### src/spq_cell.sv
// One storage cell of the queue chain: holds a record, compares it with
// an incoming record and shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_W = SPQ_PRIORITY_BITS,
   parameter int CNT_W  = 8,
   parameter int INDEX  = 0
) (
   input  logic                     clock,
   input  spq_cmd_type              cmd,
   input  logic [CNT_W-1:0]         count,
   input  logic [PRIO_W-1:0]        new_prio,
   input  logic [SPQ_TIME_BITS-1:0] new_arrival,
   input  logic [SPQ_TIME_BITS-1:0] new_service,
   input  logic                     left_keep,
   input  logic [PRIO_W-1:0]        left_prio,
   input  logic [SPQ_TIME_BITS-1:0] left_arrival,
   input  logic [SPQ_TIME_BITS-1:0] left_service,
   input  logic [PRIO_W-1:0]        right_prio,
   input  logic [SPQ_TIME_BITS-1:0] right_arrival,
   input  logic [SPQ_TIME_BITS-1:0] right_service,
   output logic                     keep,
   output logic [PRIO_W-1:0]        prio,
   output logic [SPQ_TIME_BITS-1:0] arrival,
   output logic [SPQ_TIME_BITS-1:0] service
);

   logic [PRIO_W-1:0]        prio_ff, prio_in;
   logic [SPQ_TIME_BITS-1:0] arrival_ff, arrival_in;
   logic [SPQ_TIME_BITS-1:0] service_ff, service_in;
   logic                     occupied;

   assign occupied = CNT_W'(INDEX) < count;
   // An occupied cell of equal or higher priority stays ahead of a new record.
   assign keep     = occupied && (prio_ff >= new_prio);

   always_comb begin
      prio_in    = prio_ff;
      arrival_in = arrival_ff;
      service_in = service_ff;
      if (cmd.pop) begin
         prio_in    = right_prio;
         arrival_in = right_arrival;
         service_in = right_service;
      end else if (cmd.push && !keep) begin
         if (left_keep) begin
            prio_in    = new_prio;
            arrival_in = new_arrival;
            service_in = new_service;
         end else begin
            prio_in    = left_prio;
            arrival_in = left_arrival;
            service_in = left_service;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      arrival_ff <= arrival_in;
      service_ff <= service_in;
   end

   assign prio    = prio_ff;
   assign arrival = arrival_ff;
   assign service = service_ff;

endmodule

### src/stable_priority_queue.sv
// Stable priority queue, top level: record count, command decode, result
// register and the chain of spq_cell instances. Depends on spq_pkg, spq_cell.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   op, priority_req, arrival_time,
//                                                  service_time
//   rsp_      out         rsp_valid / rsp_ready   out_valid, out_priority,
//                                                  out_arrival_time, out_service_time,
//                                                  status, entry_total, is_empty
//
// One item per cycle unless rsp_ stalls: every cell settles its next record in
// the same cycle (one compare against the new priority and a two-way neighbor
// select), and the result shows on rsp_ in the cycle after the item is accepted.
// req_ready is high while the result register is empty or being taken, so
// a stalled rsp_ side holds input off after one item.
// Synchronous active-high reset clears the count and the result valid flag;
// the cell contents are not reset and only occupied cells are ever read.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = SPQ_QUEUE_DEPTH,
   parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [7:0]                req_priority_req,
   input  logic [SPQ_TIME_BITS-1:0]  req_arrival_time,
   input  logic [SPQ_TIME_BITS-1:0]  req_service_time,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_out_valid,
   output logic [SPQ_OUT_PRIO_W-1:0] rsp_out_priority,
   output logic [SPQ_TIME_BITS-1:0]  rsp_out_arrival_time,
   output logic [SPQ_TIME_BITS-1:0]  rsp_out_service_time,
   output logic [1:0]                rsp_status,
   output logic [SPQ_TOTAL_W-1:0]    rsp_entry_total,
   output logic                      rsp_is_empty
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                      accept;
   logic                      full;
   logic                      empty;
   spq_cmd_type               cmd;
   logic [PRIORITY_BITS-1:0]  new_prio;
   logic [CNT_W-1:0]          count_ff, count_in;
   spq_status_type            status_now;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic [SPQ_OUT_PRIO_W-1:0] out_prio_ff, out_prio_in;
   logic [SPQ_TIME_BITS-1:0]  out_arr_ff, out_arr_in;
   logic [SPQ_TIME_BITS-1:0]  out_svc_ff, out_svc_in;
   logic [1:0]                status_ff, status_in;
   logic [SPQ_TOTAL_W-1:0]    total_ff, total_in;
   logic                      is_empty_ff, is_empty_in;

   logic                      keep_w    [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0]  prio_w    [QUEUE_DEPTH];
   logic [SPQ_TIME_BITS-1:0]  arrival_w [QUEUE_DEPTH];
   logic [SPQ_TIME_BITS-1:0]  service_w [QUEUE_DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign new_prio  = PRIORITY_BITS'(req_priority_req);

   always_comb begin
      cmd.push = accept && (req_op == OP_PUSH) && !full;
      cmd.pop  = accept && (req_op == OP_POP) && !empty;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status_now = STATUS_OK;
      if (accept && (req_op == OP_PUSH) && full) begin
         status_now = STATUS_FULL;
      end else if (accept && (req_op == OP_POP) && empty) begin
         status_now = STATUS_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_valid_in = out_valid_ff;
      out_prio_in  = out_prio_ff;
      out_arr_in   = out_arr_ff;
      out_svc_in   = out_svc_ff;
      status_in    = status_ff;
      total_in     = total_ff;
      is_empty_in  = is_empty_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_valid_in = cmd.pop;
         out_prio_in  = cmd.pop ? SPQ_OUT_PRIO_W'(prio_w[0]) : '0;
         out_arr_in   = cmd.pop ? arrival_w[0] : '0;
         out_svc_in   = cmd.pop ? service_w[0] : '0;
         status_in    = status_now;
         total_in     = SPQ_TOTAL_W'(count_in);
         is_empty_in  = count_in == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_prio_ff  <= out_prio_in;
      out_arr_ff   <= out_arr_in;
      out_svc_ff   <= out_svc_in;
      status_ff    <= status_in;
      total_ff     <= total_in;
      is_empty_ff  <= is_empty_in;
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                     left_keep;
         logic [PRIORITY_BITS-1:0] left_prio, right_prio;
         logic [SPQ_TIME_BITS-1:0] left_arr, left_svc, right_arr, right_svc;

         // The front cell sees the new record as its left neighbor.
         if (gi == 0) begin : g_front
            assign left_keep = 1'b1;
            assign left_prio = new_prio;
            assign left_arr  = req_arrival_time;
            assign left_svc  = req_service_time;
         end else begin : g_mid
            assign left_keep = keep_w[gi-1];
            assign left_prio = prio_w[gi-1];
            assign left_arr  = arrival_w[gi-1];
            assign left_svc  = service_w[gi-1];
         end

         // The last cell holds its own record on a pop; it is unoccupied after the pop.
         if (gi == QUEUE_DEPTH - 1) begin : g_back
            assign right_prio = prio_w[gi];
            assign right_arr  = arrival_w[gi];
            assign right_svc  = service_w[gi];
         end else begin : g_inner
            assign right_prio = prio_w[gi+1];
            assign right_arr  = arrival_w[gi+1];
            assign right_svc  = service_w[gi+1];
         end

         spq_cell #(
            .PRIO_W (PRIORITY_BITS),
            .CNT_W  (CNT_W),
            .INDEX  (gi)
         ) u_cell (
            .clock         (clock),
            .cmd           (cmd),
            .count         (count_ff),
            .new_prio      (new_prio),
            .new_arrival   (req_arrival_time),
            .new_service   (req_service_time),
            .left_keep     (left_keep),
            .left_prio     (left_prio),
            .left_arrival  (left_arr),
            .left_service  (left_svc),
            .right_prio    (right_prio),
            .right_arrival (right_arr),
            .right_service (right_svc),
            .keep          (keep_w[gi]),
            .prio          (prio_w[gi]),
            .arrival       (arrival_w[gi]),
            .service       (service_w[gi])
         );
      end
   endgenerate

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_valid        = out_valid_ff;
   assign rsp_out_priority     = out_prio_ff;
   assign rsp_out_arrival_time = out_arr_ff;
   assign rsp_out_service_time = out_svc_ff;
   assign rsp_status           = status_ff;
   assign rsp_entry_total      = total_ff;
   assign rsp_is_empty         = is_empty_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("record count beyond queue depth");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not add a record");

   a_pop_returns : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> rsp_valid && rsp_out_valid && (rsp_status == STATUS_OK))
      else $error("pop from a nonempty queue returned no record");

   a_drop_holds : assert property (@(posedge clock) disable iff (reset)
      (accept && (status_now == STATUS_FULL)) |=> count_ff == $past(count_ff))
      else $error("dropped push changed the record count");

   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop issued together");

endmodule
